@@ design/gpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_pkg
// Shared widths, types and the 3x5 font table of the glyph pixel writer.
// ----------------------------------------------------------------------------
package gpw_pkg;

    localparam int CODE_W  = 8;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int COLOR_W = 24;
    localparam int ROWS    = 5;
    localparam int COLS    = 3;
    localparam int DOTS    = ROWS * COLS;
    localparam int DOT_W   = $clog2(DOTS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLS);

    localparam int GLYPH_ADVANCE_DEF = 4;
    localparam logic [X_W-1:0] CURSOR_MAX = {X_W{1'b1}};

    typedef logic [DOTS-1:0] t_glyph;

    typedef struct packed {
        t_glyph               glyph;
        logic [X_W-1:0]       x;
        logic [Y_W-1:0]       y;
        logic [COLOR_W-1:0]   color;
    } t_job;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_dot;

    // Top row in the most significant octal digit, left column in bit 2 of a row.
    function automatic t_glyph glyph_bits(input logic [CODE_W-1:0] code);
        t_glyph g;
        case (code)
            8'h30:   g = 15'o75557;
            8'h31:   g = 15'o26227;
            8'h32:   g = 15'o71747;
            8'h33:   g = 15'o71717;
            8'h34:   g = 15'o55711;
            8'h35:   g = 15'o74717;
            8'h36:   g = 15'o74757;
            8'h37:   g = 15'o71222;
            8'h38:   g = 15'o75757;
            8'h39:   g = 15'o75717;
            8'h41:   g = 15'o25755;
            8'h42:   g = 15'o65656;
            8'h45:   g = 15'o74647;
            8'h4A:   g = 15'o11157;
            8'h4C:   g = 15'o44447;
            8'h4E:   g = 15'o57775;
            8'h50:   g = 15'o65644;
            8'h51:   g = 15'o75571;
            8'h53:   g = 15'o74717;
            8'h54:   g = 15'o72222;
            8'h59:   g = 15'o55222;
            8'h3A:   g = 15'o02020;
            8'h3E:   g = 15'o42124;
            default: g = '0;
        endcase
        return g;
    endfunction

    // Map a dot's raster position (0 = top left) to its row and column.
    function automatic t_dot dot_pos(input logic [DOT_W-1:0] p);
        t_dot d;
        case (p) inside
            [4'd0:4'd2]:   d.row = 3'd0;
            [4'd3:4'd5]:   d.row = 3'd1;
            [4'd6:4'd8]:   d.row = 3'd2;
            [4'd9:4'd11]:  d.row = 3'd3;
            default:       d.row = 3'd4;
        endcase
        case (p) inside
            4'd0, 4'd3, 4'd6, 4'd9,  4'd12: d.col = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13: d.col = 2'd1;
            default:                        d.col = 2'd2;
        endcase
        return d;
    endfunction

endpackage

@@ design/gpw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_if
// Valid/ready channels for character beats in and pixel beats out.
// ----------------------------------------------------------------------------
interface gpw_char_if;
    logic                         valid;
    logic                         ready;
    logic [gpw_pkg::CODE_W-1:0]   char_code;
    logic                         new_text;
    logic [gpw_pkg::X_W-1:0]      start_x;
    logic [gpw_pkg::Y_W-1:0]      start_y;
    logic [gpw_pkg::COLOR_W-1:0]  color;

    modport source (output valid, char_code, new_text, start_x, start_y, color,
                    input ready);
    modport sink   (input valid, char_code, new_text, start_x, start_y, color,
                    output ready);
endinterface

interface gpw_pix_if;
    logic                         valid;
    logic                         ready;
    logic [gpw_pkg::X_W-1:0]      pix_x;
    logic [gpw_pkg::Y_W-1:0]      pix_y;
    logic [gpw_pkg::COLOR_W-1:0]  pix_color;
    logic                         last_pixel;

    modport source (output valid, pix_x, pix_y, pix_color, last_pixel, input ready);
    modport sink   (input valid, pix_x, pix_y, pix_color, last_pixel, output ready);
endinterface

@@ design/glyph_pixel_writer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_pixel_writer_core
// 3x5 font character generator: one pixel write beat per lit glyph dot.
// ----------------------------------------------------------------------------
// The first pixel beat of a character passes the job queue, the scanner
// mask and the output register. Throughput: one pixel beat per cycle while
// the pixel sink is ready; the single-dot scanner in the back end emits one
// beat per lit dot (0 to 15). Blank characters are accepted but not queued.
// Reset: synchronous; cursor to column 0, queue and output stage empty.
module glyph_pixel_writer_core #(
    parameter int GLYPH_ADVANCE = gpw_pkg::GLYPH_ADVANCE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpw_char_if.sink  i_char,
    gpw_pix_if.source o_pix
);
    import gpw_pkg::*;

    logic q_ready;
    logic push;
    t_job push_job;
    logic q_valid;
    logic pop;
    t_job pop_job;

    gpw_front #(
        .GLYPH_ADVANCE(GLYPH_ADVANCE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    gpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    gpw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (pop_job),
        .o_pop     (pop),
        .o_pix     (o_pix)
    );

endmodule

@@ design/gpw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_front
// Accepts character beats, tracks the text cursor and queues lit glyphs.
// ----------------------------------------------------------------------------
module gpw_front #(
    parameter int GLYPH_ADVANCE = gpw_pkg::GLYPH_ADVANCE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gpw_char_if.sink      i_char,
    input  logic          i_q_ready,
    output logic          o_push,
    output gpw_pkg::t_job o_job
);
    import gpw_pkg::*;

    localparam logic [X_W:0] ADV = (X_W+1)'(GLYPH_ADVANCE);

    logic [X_W-1:0] r_cursor, n_cursor;
    logic [X_W-1:0] base;
    logic [X_W:0]   sum;
    logic           accept;
    t_glyph         glyph;

    assign i_char.ready = i_q_ready;
    assign accept       = i_char.valid && i_char.ready;
    assign base         = i_char.new_text ? i_char.start_x : r_cursor;
    assign sum          = {1'b0, base} + ADV;
    assign glyph        = glyph_bits(i_char.char_code);

    always_comb begin
        n_cursor = r_cursor;
        if (accept) begin
            n_cursor = sum[X_W] ? CURSOR_MAX : sum[X_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else begin
            r_cursor <= n_cursor;
        end
    end

    // Drop blank glyphs here; only the cursor moves.
    assign o_push      = accept && (glyph != '0);
    assign o_job.glyph = glyph;
    assign o_job.x     = base;
    assign o_job.y     = i_char.start_y;
    assign o_job.color = i_char.color;

    a_cursor_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_char.new_text |=> r_cursor >= $past(r_cursor))
        else $error("cursor moved backward without new text");

endmodule

@@ design/gpw_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_queue
// Two-entry job queue between the front and the pixel scanner.
// ----------------------------------------------------------------------------
module gpw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpw_pkg::t_job i_job,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output gpw_pkg::t_job o_job
);
    import gpw_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = do_pop ? ~r_rptr : r_rptr;
        n_count = r_count + 2'(i_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

endmodule

@@ design/gpw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_back
// Scans a queued glyph and emits one pixel beat per lit dot.
// ----------------------------------------------------------------------------
module gpw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  gpw_pkg::t_job i_job,
    output logic          o_pop,
    gpw_pix_if.source     o_pix
);
    import gpw_pkg::*;

    logic               r_busy, n_busy;
    t_glyph             r_mask, n_mask;
    logic [X_W-1:0]     r_x;
    logic [Y_W-1:0]     r_y;
    logic [COLOR_W-1:0] r_color;

    logic               r_out_valid, n_out_valid;
    logic [X_W-1:0]     r_pix_x;
    logic [Y_W-1:0]     r_pix_y;
    logic [COLOR_W-1:0] r_pix_color;
    logic               r_last;

    logic [DOT_W-1:0]   top_idx;
    t_dot               dot;
    t_glyph             rest;
    logic               out_free;
    logic               emit;
    logic               done;

    // Highest set bit is the next dot in raster order.
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < DOTS; i++) begin
            if (r_mask[i]) begin
                top_idx = DOT_W'(i);
            end
        end
    end

    assign dot      = dot_pos(DOT_W'(DOTS - 1) - top_idx);
    assign rest     = r_mask & ~(t_glyph'(1) << top_idx);
    assign out_free = !r_out_valid || o_pix.ready;
    assign emit     = r_busy && out_free;
    assign done     = emit && (rest == '0);
    assign o_pop    = (!r_busy || done) && i_q_valid;

    always_comb begin
        n_busy = r_busy;
        n_mask = r_mask;
        if (emit) begin
            n_mask = rest;
            if (done) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_mask = i_job.glyph;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        if (o_pop) begin
            r_x     <= i_job.x;
            r_y     <= i_job.y;
            r_color <= i_job.color;
        end
        if (emit) begin
            r_pix_x     <= r_x + X_W'(dot.col);
            r_pix_y     <= r_y + Y_W'(dot.row);
            r_pix_color <= r_color;
            r_last      <= (rest == '0);
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pix_x      = r_pix_x;
    assign o_pix.pix_y      = r_pix_y;
    assign o_pix.pix_color  = r_pix_color;
    assign o_pix.last_pixel = r_last;

    a_busy_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("scanner busy with empty glyph");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done && !o_pop |=> !r_busy)
        else $error("scanner still busy after last dot");

endmodule
